// File: rtl/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int WORD_BITS       = 32;
    localparam int DIR_ENTRIES     = 1024;
    localparam int DIR_WORDS       = DIR_ENTRIES / WORD_BITS;
    localparam int POOL_PAGES_DEF  = 4096;
    localparam int MAX_REQ_DEF     = 32;

    localparam int PAGE_W   = 20;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;
    localparam int LEN_CFG_W = 13;
    localparam int DIR_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_VIRT_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_LAST   = 3'd4;

    localparam logic [PAGE_W-1:0]    RST_VIRT_BASE = 20'd786688;
    localparam logic [PAGE_W-1:0]    RST_PHYS_BASE = 20'd512;
    localparam logic [LEN_CFG_W-1:0] RST_POOL_LEN  = 13'd4096;
    localparam logic [DIR_W-1:0]     RST_DIR_FIRST = 10'd768;
    localparam logic [DIR_W-1:0]     RST_DIR_LAST  = 10'd1022;

    typedef enum logic [STATUS_W-1:0] {
        ST_MAPPED  = 2'd0,
        ST_NO_VIRT = 2'd1,
        ST_NO_PHYS = 2'd2,
        ST_USER    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_VRD,
        S_VSCAN,
        S_MRD,
        S_MWR,
        S_PRD,
        S_PCHK,
        S_DRD,
        S_DCHK,
        S_DSET,
        S_EMIT
    } state_t;

    function automatic logic [WORD_BITS-1:0] preset_word(
        input logic [4:0]       w,
        input logic [DIR_W-1:0] first,
        input logic [DIR_W-1:0] last
    );
        logic [WORD_BITS-1:0] r;
        logic [DIR_W-1:0]     e;
        for (int b = 0; b < WORD_BITS; b++) begin
            e    = {w, 5'(b)};
            r[b] = (e >= first) && (e <= last);
        end
        return r;
    endfunction

endpackage

// File: rtl/bpa_req_if.sv
`timescale 1ns / 1ps

interface bpa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          pool_select;
    logic [bpa_pkg::COUNT_W-1:0]   page_count;

    modport source (output valid, pool_select, page_count, input ready);
    modport sink   (input valid, pool_select, page_count, output ready);
endinterface

// File: rtl/bpa_rsp_if.sv
`timescale 1ns / 1ps

interface bpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::STATUS_W-1:0]  status;
    logic [bpa_pkg::PAGE_W-1:0]    virt_page;
    logic [bpa_pkg::PAGE_W-1:0]    phys_page;
    logic                          table_created;
    logic [bpa_pkg::PAGE_W-1:0]    table_phys_page;
    logic                          last_result;

    modport source (output valid, status, virt_page, phys_page, table_created,
                    table_phys_page, last_result, input ready);
    modport sink   (input valid, status, virt_page, phys_page, table_created,
                    table_phys_page, last_result, output ready);
endinterface

// File: rtl/bpa_ram.sv
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/bitmap_page_allocator_mapper.sv
`timescale 1ns / 1ps

// Bitmap page allocator / mapper.
// req: one transaction per allocation (pool_select, page_count).
// rsp: one transaction per mapped page, last_result marks the final one;
//      failures give a single transaction with a nonzero status.
// wr_en/wr_index/wr_data: register writes, the user makes them only
// while idle; the block itself does not enforce it.
// Bitmaps live in 32-bit words of two RAMs, the directory in a third.
// The virtual first-fit scan reads each 32-bit word, then tests it
// 8 bits a cycle; marking reads and writes each word touched; each
// physical page is found by reading and checking words from the
// lowest non-full word, then by a directory read and check, plus a
// physical search and a directory write when a table page is taken.
// Each result then passes through the output stage.
// One request is handled at a time; req is ready only when idle.
// After reset both bitmap RAMs are cleared, one word a cycle,
// while req is held not ready.
// When rsp stalls, the result is held and the block waits.
module bitmap_page_allocator_mapper #(
    parameter int POOL_PAGES    = bpa_pkg::POOL_PAGES_DEF,
    parameter int MAX_REQ_PAGES = bpa_pkg::MAX_REQ_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bpa_req_if.sink                         req,
    bpa_rsp_if.source                       rsp,
    input  logic                            wr_en,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]  wr_data
);

    localparam int W      = bpa_pkg::WORD_BITS;
    localparam int NWORDS = (POOL_PAGES + W - 1) / W;
    localparam int AW     = NWORDS > 1 ? $clog2(NWORDS) : 1;
    localparam int BW     = AW + 5;
    localparam int CW     = BW + 1;
    localparam int CNT_W  = bpa_pkg::COUNT_W;
    localparam int PW     = bpa_pkg::PAGE_W;

    bpa_pkg::state_t state_reg, state_next;

    logic [PW-1:0]                   vbase_reg, pbase_reg;
    logic [bpa_pkg::LEN_CFG_W-1:0]   len_cfg_reg;
    logic [bpa_pkg::DIR_W-1:0]       pfirst_reg, plast_reg;
    logic [bpa_pkg::DIR_WORDS-1:0]   dvalid_reg;

    logic [AW-1:0]    clr_reg;
    logic [AW-1:0]    vword_reg;
    logic [1:0]       sub_reg;
    logic [CNT_W-1:0] run_reg;
    logic [CNT_W-1:0] count_reg;
    logic [BW-1:0]    start_reg;
    logic [AW-1:0]    mword_reg;
    logic [CNT_W-1:0] page_reg;
    logic [AW:0]      hint_reg;
    logic             tbl_reg;
    logic [BW-1:0]    pidx_reg;

    logic [bpa_pkg::STATUS_W-1:0] o_status_reg;
    logic [PW-1:0]                o_vp_reg, o_pp_reg, o_tp_reg;
    logic                         o_created_reg, o_last_reg;

    logic          v_we, v_re, p_we, p_re, d_we, d_re;
    logic [AW-1:0] v_waddr, v_raddr, p_waddr, p_raddr;
    logic [4:0]    d_addr;
    logic [W-1:0]  v_wdata, p_wdata, d_wdata, v_q, p_q, d_q;

    bpa_ram #(.WIDTH(W), .DEPTH(NWORDS)) u_virt (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .re(v_re), .raddr(v_raddr), .rdata(v_q)
    );

    bpa_ram #(.WIDTH(W), .DEPTH(NWORDS)) u_phys (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .re(p_re), .raddr(p_raddr), .rdata(p_q)
    );

    bpa_ram #(.WIDTH(W), .DEPTH(bpa_pkg::DIR_WORDS)) u_dir (
        .clk(clk), .we(d_we), .waddr(d_addr), .wdata(d_wdata),
        .re(d_re), .raddr(d_addr), .rdata(d_q)
    );

    // managed length, clamped to the pool size
    logic [31:0]   len32;
    logic [CW-1:0] len;
    assign len32 = (32'(len_cfg_reg) > 32'(POOL_PAGES)) ? 32'(POOL_PAGES)
                                                        : 32'(len_cfg_reg);
    assign len   = len32[CW-1:0];

    logic req_bad;
    assign req_bad = (req.page_count == '0) ||
                     (32'(req.page_count) > 32'(MAX_REQ_PAGES));

    // virtual scan, 8 bits a cycle
    logic [CW-1:0]    sc_idx, sc_at, sc_nxt;
    logic [CNT_W-1:0] sc_run;
    logic             sc_found, sc_end;

    always_comb
    begin
        sc_run   = run_reg;
        sc_found = 1'b0;
        sc_at    = '0;
        sc_idx   = '0;
        for (int j = 0; j < 8; j++)
        begin
            sc_idx = {1'b0, vword_reg, sub_reg, 3'(j)};
            if (!sc_found && (sc_idx < len))
            begin
                if (v_q[{sub_reg, 3'(j)}])
                begin
                    sc_run = '0;
                end
                else
                begin
                    sc_run = sc_run + 1'b1;
                    if (sc_run == count_reg)
                    begin
                        sc_found = 1'b1;
                        sc_at    = sc_idx + CW'(1) - CW'(count_reg);
                    end
                end
            end
        end
        sc_nxt = {1'b0, vword_reg, sub_reg, 3'b111} + CW'(1);
        sc_end = (sc_nxt >= len);
    end

    // run marking
    logic [CW-1:0]   last_idx, m_idx;
    logic [AW-1:0]   end_word;
    logic [W-1:0]    m_mask;

    assign last_idx = CW'({1'b0, start_reg}) + CW'(count_reg) - CW'(1);
    assign end_word = last_idx[BW-1:5];

    always_comb
    begin
        m_idx = '0;
        for (int b = 0; b < W; b++)
        begin
            m_idx     = {1'b0, mword_reg, 5'(b)};
            m_mask[b] = (m_idx >= CW'({1'b0, start_reg})) && (m_idx <= last_idx);
        end
    end

    // physical lowest free bit
    logic [4:0]    pz;
    logic [BW-1:0] pidx;
    logic [W-1:0]  p_set;
    logic          p_full, p_out, p_ok;

    always_comb
    begin
        pz = '0;
        for (int b = W - 1; b >= 0; b--)
        begin
            if (!p_q[b])
            begin
                pz = 5'(b);
            end
        end
    end

    assign pidx   = {hint_reg[AW-1:0], pz};
    assign p_full = &p_q;
    assign p_out  = ({hint_reg, 5'b0} >= len) ||
                    (!p_full && ({1'b0, pidx} >= len));
    assign p_ok   = !p_out && !p_full;
    assign p_set  = p_q | (W'(1) << pz);

    // page addresses and directory
    logic [CW-1:0]  vpi;
    logic [PW-1:0]  vp, pp_data, pp_new;
    logic [4:0]     dir_w, dir_b;
    logic [W-1:0]   dword;
    logic           last_page;

    assign vpi       = CW'({1'b0, start_reg}) + CW'(page_reg);
    assign vp        = vbase_reg + PW'(vpi);
    assign pp_data   = pbase_reg + PW'(pidx_reg);
    assign pp_new    = pbase_reg + PW'(pidx);
    assign dir_w     = vp[PW-1:PW-5];
    assign dir_b     = vp[PW-6:PW-10];
    assign dword     = dvalid_reg[dir_w] ? d_q
                                         : bpa_pkg::preset_word(dir_w, pfirst_reg, plast_reg);
    assign last_page = (page_reg + 1'b1) == count_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpa_pkg::S_CLEAR:
                if (clr_reg == AW'(NWORDS - 1))
                begin
                    state_next = bpa_pkg::S_IDLE;
                end
            bpa_pkg::S_IDLE:
                if (req.valid)
                begin
                    if (req.pool_select || req_bad)
                    begin
                        state_next = bpa_pkg::S_EMIT;
                    end
                    else
                    begin
                        state_next = bpa_pkg::S_VRD;
                    end
                end
            bpa_pkg::S_VRD:
                state_next = bpa_pkg::S_VSCAN;
            bpa_pkg::S_VSCAN:
                if (sc_found)
                begin
                    state_next = bpa_pkg::S_MRD;
                end
                else if (sc_end)
                begin
                    state_next = bpa_pkg::S_EMIT;
                end
                else if (sub_reg == 2'd3)
                begin
                    state_next = bpa_pkg::S_VRD;
                end
            bpa_pkg::S_MRD:
                state_next = bpa_pkg::S_MWR;
            bpa_pkg::S_MWR:
                state_next = (mword_reg == end_word) ? bpa_pkg::S_PRD : bpa_pkg::S_MRD;
            bpa_pkg::S_PRD:
                state_next = bpa_pkg::S_PCHK;
            bpa_pkg::S_PCHK:
                if (p_out)
                begin
                    state_next = bpa_pkg::S_EMIT;
                end
                else if (p_full)
                begin
                    state_next = bpa_pkg::S_PRD;
                end
                else
                begin
                    state_next = tbl_reg ? bpa_pkg::S_DSET : bpa_pkg::S_DRD;
                end
            bpa_pkg::S_DRD:
                state_next = bpa_pkg::S_DCHK;
            bpa_pkg::S_DCHK:
                state_next = dword[dir_b] ? bpa_pkg::S_EMIT : bpa_pkg::S_PRD;
            bpa_pkg::S_DSET:
                state_next = bpa_pkg::S_EMIT;
            bpa_pkg::S_EMIT:
                if (rsp.ready)
                begin
                    state_next = o_last_reg ? bpa_pkg::S_IDLE : bpa_pkg::S_PRD;
                end
            default:
                state_next = bpa_pkg::S_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        req.ready = 1'b0;
        rsp.valid = 1'b0;
        v_we = 1'b0;  v_re = 1'b0;  v_waddr = '0;  v_raddr = '0;  v_wdata = '0;
        p_we = 1'b0;  p_re = 1'b0;  p_waddr = '0;  p_raddr = '0;  p_wdata = '0;
        d_we = 1'b0;  d_re = 1'b0;  d_addr = dir_w;  d_wdata = '0;
        case (state_reg)
            bpa_pkg::S_CLEAR:
            begin
                v_we    = 1'b1;
                v_waddr = clr_reg;
                p_we    = 1'b1;
                p_waddr = clr_reg;
            end
            bpa_pkg::S_IDLE:
                req.ready = 1'b1;
            bpa_pkg::S_VRD:
            begin
                v_re    = 1'b1;
                v_raddr = vword_reg;
            end
            bpa_pkg::S_MRD:
            begin
                v_re    = 1'b1;
                v_raddr = mword_reg;
            end
            bpa_pkg::S_MWR:
            begin
                v_we    = 1'b1;
                v_waddr = mword_reg;
                v_wdata = v_q | m_mask;
            end
            bpa_pkg::S_PRD:
            begin
                p_re    = 1'b1;
                p_raddr = hint_reg[AW-1:0];
            end
            bpa_pkg::S_PCHK:
            begin
                p_we    = p_ok;
                p_waddr = hint_reg[AW-1:0];
                p_wdata = p_set;
            end
            bpa_pkg::S_DRD:
                d_re = 1'b1;
            bpa_pkg::S_DSET:
            begin
                d_we    = 1'b1;
                d_wdata = dword | (W'(1) << dir_b);
            end
            bpa_pkg::S_EMIT:
                rsp.valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign rsp.status          = o_status_reg;
    assign rsp.virt_page       = o_vp_reg;
    assign rsp.phys_page       = o_pp_reg;
    assign rsp.table_created   = o_created_reg;
    assign rsp.table_phys_page = o_tp_reg;
    assign rsp.last_result     = o_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bpa_pkg::S_CLEAR;
            vbase_reg   <= bpa_pkg::RST_VIRT_BASE;
            pbase_reg   <= bpa_pkg::RST_PHYS_BASE;
            len_cfg_reg <= bpa_pkg::RST_POOL_LEN;
            pfirst_reg  <= bpa_pkg::RST_DIR_FIRST;
            plast_reg   <= bpa_pkg::RST_DIR_LAST;
            dvalid_reg  <= '0;
            clr_reg     <= '0;
            hint_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == bpa_pkg::S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (wr_en)
            begin
                case (wr_index)
                    bpa_pkg::CFG_VIRT_BASE: vbase_reg <= wr_data;
                    bpa_pkg::CFG_PHYS_BASE: pbase_reg <= wr_data;
                    bpa_pkg::CFG_POOL_LEN:  len_cfg_reg <= wr_data[bpa_pkg::LEN_CFG_W-1:0];
                    bpa_pkg::CFG_DIR_FIRST:
                    begin
                        pfirst_reg <= wr_data[bpa_pkg::DIR_W-1:0];
                        dvalid_reg <= '0;
                    end
                    bpa_pkg::CFG_DIR_LAST:
                    begin
                        plast_reg  <= wr_data[bpa_pkg::DIR_W-1:0];
                        dvalid_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == bpa_pkg::S_DSET)
            begin
                dvalid_reg[dir_w] <= 1'b1;
            end
            if (state_reg == bpa_pkg::S_PCHK && !p_out && (p_full || &p_set))
            begin
                hint_reg <= hint_reg + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            bpa_pkg::S_IDLE:
            begin
                count_reg     <= req.page_count;
                vword_reg     <= '0;
                sub_reg       <= '0;
                run_reg       <= '0;
                o_vp_reg      <= '0;
                o_pp_reg      <= '0;
                o_tp_reg      <= '0;
                o_created_reg <= 1'b0;
                o_last_reg    <= 1'b1;
                o_status_reg  <= req.pool_select ? bpa_pkg::ST_USER : bpa_pkg::ST_NO_VIRT;
            end
            bpa_pkg::S_VSCAN:
            begin
                run_reg   <= sc_run;
                sub_reg   <= sub_reg + 1'b1;
                start_reg <= sc_at[BW-1:0];
                mword_reg <= sc_at[BW-1:5];
                if (sub_reg == 2'd3)
                begin
                    vword_reg <= vword_reg + 1'b1;
                end
            end
            bpa_pkg::S_MWR:
            begin
                mword_reg <= mword_reg + 1'b1;
                page_reg  <= '0;
                tbl_reg   <= 1'b0;
            end
            bpa_pkg::S_PCHK:
            begin
                if (p_out)
                begin
                    o_status_reg  <= bpa_pkg::ST_NO_PHYS;
                    o_vp_reg      <= vp;
                    o_pp_reg      <= tbl_reg ? pp_data : '0;
                    o_created_reg <= 1'b0;
                    o_tp_reg      <= '0;
                    o_last_reg    <= 1'b1;
                end
                else if (!p_full)
                begin
                    if (tbl_reg)
                    begin
                        o_tp_reg <= pp_new;
                    end
                    else
                    begin
                        pidx_reg <= pidx;
                    end
                end
            end
            bpa_pkg::S_DCHK:
            begin
                tbl_reg       <= 1'b1;
                o_status_reg  <= bpa_pkg::ST_MAPPED;
                o_vp_reg      <= vp;
                o_pp_reg      <= pp_data;
                o_created_reg <= 1'b0;
                o_tp_reg      <= '0;
                o_last_reg    <= last_page;
            end
            bpa_pkg::S_DSET:
            begin
                o_status_reg  <= bpa_pkg::ST_MAPPED;
                o_vp_reg      <= vp;
                o_pp_reg      <= pp_data;
                o_created_reg <= 1'b1;
                o_last_reg    <= last_page;
            end
            bpa_pkg::S_EMIT:
            begin
                if (rsp.ready)
                begin
                    page_reg <= page_reg + 1'b1;
                    tbl_reg  <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: dv/bpa_alloc_checker.sv
`timescale 1ns / 1ps

module bpa_alloc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    bpa_req_if                             req,
    bpa_rsp_if                             rsp,
    input  logic                           wr_en,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0] wr_data,
    output int                             outstanding,
    output int                             errors
);

    localparam int POOL   = bpa_pkg::POOL_PAGES_DEF;
    localparam int PAGE_W = bpa_pkg::PAGE_W;
    localparam int LEN_W  = bpa_pkg::LEN_CFG_W;
    localparam int DIR_W  = bpa_pkg::DIR_W;
    localparam int DIRS   = bpa_pkg::DIR_ENTRIES;

    typedef struct packed {
        bpa_pkg::status_t  status;
        logic [PAGE_W-1:0] virt_page;
        logic [PAGE_W-1:0] phys_page;
        logic              table_created;
        logic [PAGE_W-1:0] table_phys_page;
        logic              last_result;
    } page_result_t;

    page_result_t expected_pages[$];

    logic [PAGE_W-1:0] virt_base;
    logic [PAGE_W-1:0] phys_base;
    logic [LEN_W-1:0]  pool_len;
    logic [DIR_W-1:0]  dir_first;
    logic [DIR_W-1:0]  dir_last;

    bit virt_used[POOL];
    bit phys_used[POOL];
    bit dir_present[DIRS];

    function automatic void load_dir_preset(logic [DIR_W-1:0] first, logic [DIR_W-1:0] last);
        for (int i = 0; i < DIRS; i++)
            dir_present[i] = (i >= first) && (i <= last);
    endfunction

    // first-fit run of n clear bits, -1 when none
    function automatic int first_free_run(bit in_phys, int n);
        int span;
        int run;
        span = (pool_len > POOL) ? POOL : int'(pool_len);
        run  = 0;
        for (int i = 0; i < span; i++) begin
            if (in_phys ? phys_used[i] : virt_used[i])
                run = 0;
            else begin
                run++;
                if (run == n)
                    return i + 1 - n;
            end
        end
        return -1;
    endfunction

    function automatic void push_page(bpa_pkg::status_t st, logic [PAGE_W-1:0] vp,
                                      logic [PAGE_W-1:0] pp, logic tc,
                                      logic [PAGE_W-1:0] tp, logic last);
        page_result_t r;
        r.status          = st;
        r.virt_page       = vp;
        r.phys_page       = pp;
        r.table_created   = tc;
        r.table_phys_page = tp;
        r.last_result     = last;
        expected_pages.push_back(r);
    endfunction

    function automatic void predict_request(logic pool_sel,
                                            logic [bpa_pkg::COUNT_W-1:0] count);
        int start;
        int pidx;
        int tidx;
        logic [PAGE_W-1:0] vp;
        logic [PAGE_W-1:0] pp;
        logic [PAGE_W-1:0] tp;
        logic tc;
        if (pool_sel) begin
            push_page(bpa_pkg::ST_USER, '0, '0, 1'b0, '0, 1'b1);
            return;
        end
        start = -1;
        if (count != 0 && count <= bpa_pkg::MAX_REQ_DEF)
            start = first_free_run(1'b0, int'(count));
        if (start < 0) begin
            push_page(bpa_pkg::ST_NO_VIRT, '0, '0, 1'b0, '0, 1'b1);
            return;
        end
        for (int i = 0; i < count; i++)
            virt_used[start + i] = 1'b1;
        for (int i = 0; i < count; i++) begin
            vp = virt_base + PAGE_W'(start + i);
            pidx = first_free_run(1'b1, 1);
            if (pidx < 0) begin
                push_page(bpa_pkg::ST_NO_PHYS, vp, '0, 1'b0, '0, 1'b1);
                return;
            end
            phys_used[pidx] = 1'b1;
            pp = phys_base + PAGE_W'(pidx);
            tc = 1'b0;
            tp = '0;
            if (!dir_present[vp[PAGE_W-1:10]]) begin
                tidx = first_free_run(1'b1, 1);
                if (tidx < 0) begin
                    push_page(bpa_pkg::ST_NO_PHYS, vp, pp, 1'b0, '0, 1'b1);
                    return;
                end
                phys_used[tidx] = 1'b1;
                dir_present[vp[PAGE_W-1:10]] = 1'b1;
                tc = 1'b1;
                tp = phys_base + PAGE_W'(tidx);
            end
            push_page(bpa_pkg::ST_MAPPED, vp, pp, tc, tp, i + 1 == count);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        page_result_t got;
        page_result_t want;
        if (!rst_n) begin
            virt_base = bpa_pkg::RST_VIRT_BASE;
            phys_base = bpa_pkg::RST_PHYS_BASE;
            pool_len  = bpa_pkg::RST_POOL_LEN;
            dir_first = bpa_pkg::RST_DIR_FIRST;
            dir_last  = bpa_pkg::RST_DIR_LAST;
            for (int i = 0; i < POOL; i++) begin
                virt_used[i] = 1'b0;
                phys_used[i] = 1'b0;
            end
            load_dir_preset(dir_first, dir_last);
            expected_pages.delete();
            outstanding = 0;
            errors      = 0;
        end else begin
            if (wr_en) begin
                case (wr_index)
                    bpa_pkg::CFG_VIRT_BASE: virt_base = wr_data[PAGE_W-1:0];
                    bpa_pkg::CFG_PHYS_BASE: phys_base = wr_data[PAGE_W-1:0];
                    bpa_pkg::CFG_POOL_LEN:  pool_len  = wr_data[LEN_W-1:0];
                    bpa_pkg::CFG_DIR_FIRST:
                    begin
                        dir_first = wr_data[DIR_W-1:0];
                        load_dir_preset(dir_first, dir_last);
                    end
                    bpa_pkg::CFG_DIR_LAST:
                    begin
                        dir_last = wr_data[DIR_W-1:0];
                        load_dir_preset(dir_first, dir_last);
                    end
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready) begin
                got.status          = bpa_pkg::status_t'(rsp.status);
                got.virt_page       = rsp.virt_page;
                got.phys_page       = rsp.phys_page;
                got.table_created   = rsp.table_created;
                got.table_phys_page = rsp.table_phys_page;
                got.last_result     = rsp.last_result;
                if (expected_pages.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction, actual %p", $realtime, got);
                end else begin
                    want = expected_pages.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $realtime, want, got);
                    end
                end
            end
            if (req.valid && req.ready)
                predict_request(req.pool_select, req.page_count);
            outstanding = expected_pages.size();
        end
    end

endmodule

// File: dv/tb_bitmap_page_allocator_mapper.sv
`timescale 1ns / 1ps

module tb_bitmap_page_allocator_mapper;

    localparam int COUNT_W = bpa_pkg::COUNT_W;
    localparam int PAGE_W  = bpa_pkg::PAGE_W;
    localparam int DATA_W  = bpa_pkg::CFG_DATA_W;

    logic                            clk;
    logic                            rst_n;
    logic                            wr_en;
    logic [bpa_pkg::CFG_IDX_W-1:0]   wr_index;
    logic [DATA_W-1:0]               wr_data;
    int                              outstanding;
    int                              errors;
    int                              burst_left;
    int                              stall_mode;
    int                              stall_cnt;

    bpa_req_if req_if();
    bpa_rsp_if rsp_if();

    bitmap_page_allocator_mapper u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_if.sink),
        .rsp      (rsp_if.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    bpa_alloc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .outstanding (outstanding),
        .errors      (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("bitmap_page_allocator_mapper verification failed");
        $finish;
    end

    // receiver stall pattern: always ready, random, or a repeating on/off pattern
    always @(negedge clk)
    begin
        if (stall_cnt == 0)
            stall_mode <= $urandom_range(0, 2);
        stall_cnt <= (stall_cnt + 1) % 64;
        case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            default: rsp_if.ready <= (stall_cnt % 8) < 3;
        endcase
    end

    task automatic send_request(logic pool_sel, logic [COUNT_W-1:0] count);
        int gap;
        @(negedge clk);
        req_if.valid       <= 1'b1;
        req_if.pool_select <= pool_sel;
        req_if.page_count  <= count;
        do
            @(posedge clk);
        while (!req_if.ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, 12);
            burst_left = $urandom_range(0, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                req_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            send_request(1'b1, COUNT_W'($urandom_range(0, 63)));
        else if (r < 12)
            send_request(1'b0, '0);
        else if (r < 16)
            send_request(1'b0, COUNT_W'($urandom_range(33, 63)));
        else
            send_request(1'b0, COUNT_W'($urandom_range(1, 32)));
    endtask

    // drain, then write all registers while idle
    task automatic configure(logic [PAGE_W-1:0] vbase, logic [PAGE_W-1:0] pbase,
                             logic [bpa_pkg::LEN_CFG_W-1:0] len,
                             logic [bpa_pkg::DIR_W-1:0] first,
                             logic [bpa_pkg::DIR_W-1:0] last);
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        while (!req_if.ready)
            @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= bpa_pkg::CFG_VIRT_BASE;
        wr_data  <= vbase;
        @(negedge clk);
        wr_index <= bpa_pkg::CFG_PHYS_BASE;
        wr_data  <= pbase;
        @(negedge clk);
        wr_index <= bpa_pkg::CFG_POOL_LEN;
        wr_data  <= DATA_W'(len);
        @(negedge clk);
        wr_index <= bpa_pkg::CFG_DIR_FIRST;
        wr_data  <= DATA_W'(first);
        @(negedge clk);
        wr_index <= bpa_pkg::CFG_DIR_LAST;
        wr_data  <= DATA_W'(last);
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        wr_en              = 1'b0;
        wr_index           = '0;
        wr_data            = '0;
        req_if.valid       = 1'b0;
        req_if.pool_select = 1'b0;
        req_if.page_count  = '0;
        rsp_if.ready       = 1'b0;
        stall_mode         = 0;
        stall_cnt          = 0;
        burst_left         = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        while (!req_if.ready)
            @(negedge clk);

        // directed, reset settings
        send_request(1'b0, 6'd1);
        send_request(1'b0, 6'd32);
        send_request(1'b1, 6'd5);
        send_request(1'b1, 6'd0);
        send_request(1'b1, 6'd63);
        send_request(1'b0, 6'd0);
        send_request(1'b0, 6'd33);
        send_request(1'b0, 6'd63);
        send_request(1'b0, 6'd31);

        // empty directory preset, small pool: tables and phys exhaustion
        configure(20'd1020, 20'd0, 13'd48, 10'd1023, 10'd0);
        send_request(1'b0, 6'd3);
        send_request(1'b0, 6'd6);
        send_request(1'b0, 6'd16);
        send_request(1'b0, 6'd20);
        send_request(1'b0, 6'd2);
        send_request(1'b0, 6'd1);
        repeat (6) random_request();

        configure(20'hFFFF0, 20'hFFFFF, 13'd120, 10'd0, 10'd1023);
        repeat (40) random_request();

        configure(20'd3072, 20'd7, 13'd0, 10'd5, 10'd5);
        repeat (10) random_request();

        configure(20'd0, 20'd100, 13'd8191, 10'd0, 10'd0);
        repeat (200) random_request();

        configure(bpa_pkg::RST_VIRT_BASE, bpa_pkg::RST_PHYS_BASE, bpa_pkg::RST_POOL_LEN,
                  bpa_pkg::RST_DIR_FIRST, bpa_pkg::RST_DIR_LAST);
        repeat (190) random_request();

        @(negedge clk);
        req_if.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (1000) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("bitmap_page_allocator_mapper verification clean");
        else
            $display("bitmap_page_allocator_mapper verification failed");
        $finish;
    end

endmodule
